### src/esp_pkg.sv
// ----------------------------------------------------------------------------
// esp_pkg
// Shared types and codes for the ELF64 segment page placer.
// ----------------------------------------------------------------------------
`default_nettype none

package esp_pkg;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_OOM     = 2'd1,
        ST_OVERLAP = 2'd2,
        ST_TOOMANY = 2'd3
    } t_status;

    // Configuration register indexes
    localparam logic CFG_REGION_BASE  = 1'b0;
    localparam logic CFG_REGION_LIMIT = 1'b1;

    // Placement sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_OPEN,
        S_CHECK,
        S_ALIGN,
        S_VEND,
        S_SCAN,
        S_PEND,
        S_PADDR,
        S_RESULT
    } t_state;

    // Sequencer to scan unit
    typedef struct packed {
        logic start;
        logic wr;
    } t_scan_ctl;

    // Scan unit to sequencer
    typedef struct packed {
        logic done;
        logic hit;
    } t_scan_sts;

endpackage

`default_nettype wire

### src/esp_ram.sv
// ----------------------------------------------------------------------------
// esp_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module esp_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

### src/esp_scan.sv
// ----------------------------------------------------------------------------
// esp_scan
// Table of placed page ranges and the overlap scan over it, one entry per
// cycle through the RAM read port.
// ----------------------------------------------------------------------------
`default_nettype none

module esp_scan
    import esp_pkg::*;
#(
    parameter int MAX_PLACED = 16,
    parameter int CNT_W      = $clog2(MAX_PLACED + 1),
    parameter int IDX_W      = (MAX_PLACED > 1) ? $clog2(MAX_PLACED) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_scan_ctl        i_ctl,
    output t_scan_sts             o_sts,
    input  wire logic [CNT_W-1:0] i_count,
    input  wire logic [63:0]      i_vpage,
    input  wire logic [63:0]      i_vend
);

    logic             r_active;
    logic             r_rvalid;
    logic             r_hit;
    logic [CNT_W-1:0] r_idx;
    logic [CNT_W-1:0] r_cnt;
    logic [127:0]     rdata;
    logic [63:0]      old_vpage;
    logic [63:0]      old_vend;
    logic             issue;
    logic             hit_now;
    logic             scan_done;

    // Entry layout: {vpage, vend}
    esp_ram #(
        .WIDTH (128),
        .DEPTH (MAX_PLACED),
        .AW    (IDX_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_ctl.wr),
        .i_waddr (i_count[IDX_W-1:0]),
        .i_wdata ({i_vpage, i_vend}),
        .i_raddr (r_idx[IDX_W-1:0]),
        .o_rdata (rdata)
    );

    assign old_vpage = rdata[127:64];
    assign old_vend  = rdata[63:0];
    assign issue     = r_active && (r_idx != r_cnt);
    // Half-open page ranges intersect
    assign hit_now   = r_rvalid && (i_vpage < old_vend) && (old_vpage < i_vend);

    assign scan_done = r_active && !issue && !r_rvalid;
    assign o_sts     = '{done: scan_done, hit: r_hit};

    // Scan sequencing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_rvalid <= 1'b0;
            r_hit    <= 1'b0;
            r_idx    <= '0;
            r_cnt    <= '0;
        end else if (i_ctl.start) begin
            r_active <= 1'b1;
            r_rvalid <= 1'b0;
            r_hit    <= 1'b0;
            r_idx    <= '0;
            r_cnt    <= i_count;
        end else begin
            r_rvalid <= issue;
            if (issue) begin
                r_idx <= r_idx + 1'b1;
            end
            if (hit_now) begin
                r_hit <= 1'b1;
            end
            if (scan_done) begin
                r_active <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

### src/elf64_segment_page_placer.sv
// ----------------------------------------------------------------------------
// elf64_segment_page_placer
// Places loadable ELF64 segments page by page into a physical region.
// ----------------------------------------------------------------------------
// One segment is taken when start is high and busy is low; its result shows
// on the o_ ports for exactly one cycle with o_valid high and cannot be held
// off. A placed segment passes the open step (only when it opens a plan),
// then check, align, virtual end, overlap scan, physical end and physical
// address steps before its result: the overlap check reads the placed-range
// memory one entry per cycle through its registered read port, and every
// 64-bit sum goes through a single shared adder, one per cycle. Busy drops
// the cycle after the strobe, so the next segment can be taken in that
// cycle. Segments failing early or arriving with an error in force finish
// sooner. Region base and limit are written through the i_cfg_ port while
// busy is low; the user must keep to this, the block does not enforce it.
`default_nettype none

module elf64_segment_page_placer
    import esp_pkg::*;
#(
    parameter int MAX_PLACED = 16,
    parameter int PAGE_SHIFT = 12
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_idx,
    input  wire logic [63:0] i_cfg_data,
    // segment item
    input  wire logic        start,
    output logic             busy,
    input  wire logic [63:0] i_virt_addr,
    input  wire logic [63:0] i_mem_bytes,
    input  wire logic [63:0] i_file_pos,
    input  wire logic [63:0] i_file_bytes,
    input  wire logic [31:0] i_perm_bits,
    input  wire logic        i_last_segment,
    // result item
    output logic             o_valid,
    output logic [1:0]       o_status,
    output logic [63:0]      o_virt_page,
    output logic [63:0]      o_phys_frame,
    output logic [63:0]      o_phys_addr,
    output logic [52:0]      o_pages,
    output logic [63:0]      o_out_file_pos,
    output logic [63:0]      o_out_file_bytes,
    output logic [63:0]      o_out_mem_bytes,
    output logic [31:0]      o_out_perm_bits,
    output logic [63:0]      o_plan_start,
    output logic [63:0]      o_plan_end,
    output logic             o_last_result
);

    localparam int          CNT_W   = $clog2(MAX_PLACED + 1);
    localparam logic [63:0] PG_MASK = (64'd1 << PAGE_SHIFT) - 64'd1;

    // Control state
    t_state           r_state, n_state;
    t_status          r_sticky;
    t_status          r_status;
    logic             r_in_plan;
    logic [CNT_W-1:0] r_count;

    // Plan and config registers
    logic [63:0] r_base, r_limit;
    logic [63:0] r_cursor, r_start;

    // Item payload and working registers
    logic [63:0] r_vpage, r_off, r_mem, r_file_pos, r_file_bytes;
    logic [31:0] r_perm;
    logic        r_last;
    logic [63:0] r_work;    // span, then page-aligned size
    logic [63:0] r_vend;
    logic [63:0] r_pend;
    logic [63:0] r_paddr;

    // Shared adder
    logic [63:0] add_a, add_b;
    logic [64:0] add_sum;
    logic        carry;
    logic [63:0] sum_lo;
    logic [63:0] rounded;

    // Step outcome
    logic    fail;
    t_status fail_code;

    t_scan_ctl scan_ctl;
    t_scan_sts scan_sts;

    // Adder operand select
    always_comb begin
        unique case (r_state)
            S_OPEN:  begin add_a = r_base;   add_b = PG_MASK; end
            S_CHECK: begin add_a = r_off;    add_b = r_mem;   end
            S_ALIGN: begin add_a = r_work;   add_b = PG_MASK; end
            S_VEND:  begin add_a = r_vpage;  add_b = r_work;  end
            S_PEND:  begin add_a = r_cursor; add_b = r_work;  end
            S_PADDR: begin add_a = r_cursor; add_b = r_off;   end
            default: begin add_a = '0;       add_b = '0;      end
        endcase
    end

    assign add_sum = {1'b0, add_a} + {1'b0, add_b};
    assign carry   = add_sum[64];
    assign sum_lo  = add_sum[63:0];
    assign rounded = sum_lo & ~PG_MASK;

    // Failure detection per step
    always_comb begin
        fail      = 1'b0;
        fail_code = ST_OOM;
        unique case (r_state)
            S_CHECK: begin
                if (r_sticky != ST_OK) begin
                    fail      = 1'b1;
                    fail_code = r_sticky;
                end else if (r_count >= CNT_W'(MAX_PLACED)) begin
                    fail      = 1'b1;
                    fail_code = ST_TOOMANY;
                end else if (carry) begin
                    fail = 1'b1;
                end
            end
            S_ALIGN: fail = carry || (rounded == '0);
            S_VEND:  fail = carry;
            S_SCAN: begin
                fail      = scan_sts.done && scan_sts.hit;
                fail_code = ST_OVERLAP;
            end
            S_PEND:  fail = carry || (sum_lo > r_limit);
            default: fail = 1'b0;
        endcase
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (start) n_state = r_in_plan ? S_CHECK : S_OPEN;
            S_OPEN:   n_state = S_CHECK;
            S_CHECK:  n_state = fail ? S_RESULT : S_ALIGN;
            S_ALIGN:  n_state = fail ? S_RESULT : S_VEND;
            S_VEND:   n_state = fail ? S_RESULT : S_SCAN;
            S_SCAN:   if (scan_sts.done) n_state = fail ? S_RESULT : S_PEND;
            S_PEND:   n_state = fail ? S_RESULT : S_PADDR;
            S_PADDR:  n_state = S_RESULT;
            S_RESULT: n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        busy           = (r_state != S_IDLE);
        scan_ctl.start = (r_state == S_VEND) && !fail;
        scan_ctl.wr    = (r_state == S_PADDR);
        o_valid        = (r_state == S_RESULT);
    end

    // Physical frame of a placed segment is the cursor before it advanced
    assign o_status         = r_status;
    assign o_virt_page      = (r_status == ST_OK) ? r_vpage : '0;
    assign o_phys_frame     = (r_status == ST_OK) ? (r_pend - r_work) : '0;
    assign o_phys_addr      = (r_status == ST_OK) ? r_paddr : '0;
    assign o_pages          = (r_status == ST_OK) ? 53'(r_work >> PAGE_SHIFT) : '0;
    assign o_out_file_pos   = r_file_pos;
    assign o_out_file_bytes = r_file_bytes;
    assign o_out_mem_bytes  = r_mem;
    assign o_out_perm_bits  = r_perm;
    assign o_plan_start     = r_start;
    assign o_plan_end       = r_cursor;
    assign o_last_result    = r_last;

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_sticky  <= ST_OK;
            r_status  <= ST_OK;
            r_in_plan <= 1'b0;
            r_count   <= '0;
            r_base    <= '0;
            r_limit   <= '0;
            r_cursor  <= '0;
            r_start   <= '0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_REGION_BASE:  r_base  <= i_cfg_data;
                    CFG_REGION_LIMIT: r_limit <= i_cfg_data;
                    default:          r_base  <= r_base;
                endcase
            end

            // Plan open: cursor at rounded base
            if (r_state == S_OPEN) begin
                r_in_plan <= 1'b1;
                r_count   <= '0;
                r_cursor  <= carry ? '0 : rounded;
                r_start   <= carry ? '0 : rounded;
                r_sticky  <= (carry || (rounded >= r_limit)) ? ST_OOM : ST_OK;
            end

            // Failure: report it and hold it for the rest of the plan
            if (fail) begin
                r_status <= fail_code;
                r_sticky <= fail_code;
            end

            // Commit a placed segment
            if (r_state == S_PADDR) begin
                r_status <= ST_OK;
                r_cursor <= r_pend;
                r_count  <= r_count + 1'b1;
            end

            // Plan close after the last segment
            if (r_state == S_RESULT && r_last) begin
                r_in_plan <= 1'b0;
                r_sticky  <= ST_OK;
                r_count   <= '0;
            end
        end
    end

    // Payload and working registers
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && start) begin
            r_vpage      <= i_virt_addr & ~PG_MASK;
            r_off        <= i_virt_addr & PG_MASK;
            r_mem        <= i_mem_bytes;
            r_file_pos   <= i_file_pos;
            r_file_bytes <= i_file_bytes;
            r_perm       <= i_perm_bits;
            r_last       <= i_last_segment;
        end
        if (r_state == S_CHECK) begin
            r_work <= sum_lo;
        end
        if (r_state == S_ALIGN) begin
            r_work <= rounded;
        end
        if (r_state == S_VEND) begin
            r_vend <= sum_lo;
        end
        if (r_state == S_PEND) begin
            r_pend <= sum_lo;
        end
        if (r_state == S_PADDR) begin
            r_paddr <= sum_lo;
        end
    end

    esp_scan #(
        .MAX_PLACED (MAX_PLACED)
    ) u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (scan_ctl),
        .o_sts   (scan_sts),
        .i_count (r_count),
        .i_vpage (r_vpage),
        .i_vend  (r_vend)
    );

`ifndef SYNTHESIS
    // A result is a single-cycle strobe and frees the block right after
    a_result_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> (!o_valid && !busy))
        else $error("result strobe longer than one cycle or block stayed busy");

    // Placed count never passes the table depth
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_PLACED))
        else $error("placed count beyond table depth");

    // Scan completion only while the sequencer waits for it
    a_scan_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        scan_sts.done |-> (r_state == S_SCAN))
        else $error("scan finished outside the scan step");

    // A successful placement stays within the region limit
    a_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == ST_OK)) |-> (r_cursor <= r_limit))
        else $error("placement ends past the region limit");
`endif

endmodule

`default_nettype wire

### bench/elf64_segment_page_placer_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// elf64_segment_page_placer_tb
// Self-checking bench for the ELF64 segment page placer. A scoreboard class
// keeps its own copy of the placement state (cursor, placed page ranges,
// error in force) and predicts one placement per accepted segment. Each
// strobed result is checked field by field. Directed segments hit the
// overflow, empty, overlap and slot-exhaustion cases. Random plans follow
// under many region settings, with idle gaps on the segment side.
// ----------------------------------------------------------------------------

import esp_pkg::*;

localparam int          PAGE_BITS   = 12;
localparam int          PLACE_SLOTS = 16;
localparam logic [63:0] PAGE_MASK   = (64'd1 << PAGE_BITS) - 64'd1;
localparam logic [63:0] ADDR_MAX    = '1;

// one segment item as driven into the block
typedef struct {
    logic [63:0] virt_addr;
    logic [63:0] mem_bytes;
    logic [63:0] file_pos;
    logic [63:0] file_bytes;
    logic [31:0] perm_bits;
    logic        last;
} t_segment;

// one placement result as seen on the o_ ports
typedef struct {
    t_status     status;
    logic [63:0] virt_page;
    logic [63:0] phys_frame;
    logic [63:0] phys_addr;
    logic [52:0] pages;
    logic [63:0] file_pos;
    logic [63:0] file_bytes;
    logic [63:0] mem_bytes;
    logic [31:0] perm_bits;
    logic [63:0] plan_start;
    logic [63:0] plan_end;
    logic        last;
} t_placement;

class placement_scoreboard;
    logic [63:0] reg_base;
    logic [63:0] reg_limit;
    logic [63:0] phys_cursor;
    logic [63:0] plan_origin;
    logic [63:0] seg_vpage [PLACE_SLOTS];
    logic [52:0] seg_npages [PLACE_SLOTS];
    int          n_placed;
    t_status     plan_err;
    bit          plan_open;
    t_placement  placement_q[$];
    int          n_checked;
    int          n_mismatch;
    int          status_seen [4];

    function new();
        reg_base    = '0;
        reg_limit   = '0;
        phys_cursor = '0;
        plan_origin = '0;
        n_placed    = 0;
        plan_err    = ST_OK;
        plan_open   = 1'b0;
        n_checked   = 0;
        n_mismatch  = 0;
        foreach (status_seen[k]) status_seen[k] = 0;
    endfunction

    function void set_region(logic [63:0] base, logic [63:0] limit);
        reg_base  = base;
        reg_limit = limit;
    endfunction

    function int pending();
        return placement_q.size();
    endfunction

    // predict the placement of an accepted segment
    function void note_item(t_segment s);
        t_placement  p;
        logic [64:0] sum;
        logic [63:0] vpage, off, span, aligned, vend, oend, npg;
        t_status     st;
        int          i;

        // first segment of a plan: cursor from the rounded-up base
        if (!plan_open) begin
            plan_open = 1'b1;
            n_placed  = 0;
            plan_err  = ST_OK;
            if (reg_base > ADDR_MAX - PAGE_MASK) begin
                phys_cursor = '0;
                plan_err    = ST_OOM;
            end else begin
                phys_cursor = (reg_base + PAGE_MASK) & ~PAGE_MASK;
                if (phys_cursor >= reg_limit) plan_err = ST_OOM;
            end
            plan_origin = phys_cursor;
        end

        st      = plan_err;
        vpage   = s.virt_addr & ~PAGE_MASK;
        off     = s.virt_addr & PAGE_MASK;
        aligned = '0;
        vend    = '0;
        sum     = '0;

        // slot check comes before any range arithmetic
        if (st == ST_OK && n_placed >= PLACE_SLOTS) st = ST_TOOMANY;

        // widen to whole pages, every sum checked for carry-out
        if (st == ST_OK) begin
            sum  = {1'b0, off} + {1'b0, s.mem_bytes};
            span = sum[63:0];
            if (sum[64] || span > ADDR_MAX - PAGE_MASK) begin
                st = ST_OOM;
            end else begin
                aligned = (span + PAGE_MASK) & ~PAGE_MASK;
                if (aligned == '0) st = ST_OOM;
            end
        end
        if (st == ST_OK) begin
            sum  = {1'b0, vpage} + {1'b0, aligned};
            vend = sum[63:0];
            if (sum[64]) st = ST_OOM;
        end

        // overlap scan, in placement order, first hit decides
        for (i = 0; i < n_placed && st == ST_OK; i++) begin
            npg  = 64'(seg_npages[i]);
            sum  = {1'b0, seg_vpage[i]} + {1'b0, npg << PAGE_BITS};
            oend = sum[63:0];
            if (npg > (ADDR_MAX >> PAGE_BITS) || sum[64]) st = ST_OOM;
            else if (vpage < oend && seg_vpage[i] < vend) st = ST_OVERLAP;
        end

        // physical end against the region limit
        if (st == ST_OK) begin
            sum = {1'b0, phys_cursor} + {1'b0, aligned};
            if (sum[64] || sum[63:0] > reg_limit) st = ST_OOM;
        end

        p.status     = st;
        p.virt_page  = '0;
        p.phys_frame = '0;
        p.phys_addr  = '0;
        p.pages      = '0;
        if (st == ST_OK) begin
            seg_vpage[n_placed]  = vpage;
            seg_npages[n_placed] = 53'(aligned >> PAGE_BITS);
            n_placed++;
            p.virt_page  = vpage;
            p.phys_frame = phys_cursor;
            p.phys_addr  = phys_cursor + off;
            p.pages      = 53'(aligned >> PAGE_BITS);
            phys_cursor  = sum[63:0];
        end
        plan_err = st;

        p.file_pos   = s.file_pos;
        p.file_bytes = s.file_bytes;
        p.mem_bytes  = s.mem_bytes;
        p.perm_bits  = s.perm_bits;
        p.plan_start = plan_origin;
        p.plan_end   = phys_cursor;
        p.last       = s.last;

        // last segment closes the plan
        if (s.last) begin
            plan_open = 1'b0;
            plan_err  = ST_OK;
            n_placed  = 0;
        end
        status_seen[st]++;
        placement_q.push_back(p);
    endfunction

    task report_mismatch(string msg);
        n_mismatch++;
        if (n_mismatch <= 30) $display("[%0t] MISMATCH %s", $time, msg);
    endtask

    task check_field(string what, logic [63:0] got, logic [63:0] want);
        if (got !== want) report_mismatch($sformatf("%s: got %h, expected %h", what, got, want));
    endtask

    // compare a strobed result with the oldest prediction
    task check_result(t_placement got);
        t_placement want;
        string      tag;
        if (placement_q.size() == 0) begin
            report_mismatch("result strobed with no segment outstanding");
            return;
        end
        want = placement_q.pop_front();
        tag  = $sformatf("result %0d", n_checked);
        n_checked++;
        check_field({tag, " status"},     got.status,     want.status);
        check_field({tag, " virt_page"},  got.virt_page,  want.virt_page);
        check_field({tag, " phys_frame"}, got.phys_frame, want.phys_frame);
        check_field({tag, " phys_addr"},  got.phys_addr,  want.phys_addr);
        check_field({tag, " pages"},      got.pages,      want.pages);
        check_field({tag, " file_pos"},   got.file_pos,   want.file_pos);
        check_field({tag, " file_bytes"}, got.file_bytes, want.file_bytes);
        check_field({tag, " mem_bytes"},  got.mem_bytes,  want.mem_bytes);
        check_field({tag, " perm_bits"},  got.perm_bits,  want.perm_bits);
        check_field({tag, " plan_start"}, got.plan_start, want.plan_start);
        check_field({tag, " plan_end"},   got.plan_end,   want.plan_end);
        check_field({tag, " last"},       got.last,       want.last);
    endtask
endclass

module elf64_segment_page_placer_tb;

    localparam int N_ITEMS = 750;

    // pass-through fill for directed and random segments
    localparam int FILL_ZERO   = 0;
    localparam int FILL_ONES   = 1;
    localparam int FILL_RANDOM = 2;

    typedef enum {
        SEG_NORMAL,
        SEG_NOISE,
        SEG_OVERLAP,
        SEG_EMPTY,
        SEG_HUGE
    } t_seg_kind;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_idx;
    logic [63:0] i_cfg_data;
    logic        start;
    logic        busy;
    logic [63:0] i_virt_addr;
    logic [63:0] i_mem_bytes;
    logic [63:0] i_file_pos;
    logic [63:0] i_file_bytes;
    logic [31:0] i_perm_bits;
    logic        i_last_segment;
    logic        o_valid;
    logic [1:0]  o_status;
    logic [63:0] o_virt_page;
    logic [63:0] o_phys_frame;
    logic [63:0] o_phys_addr;
    logic [52:0] o_pages;
    logic [63:0] o_out_file_pos;
    logic [63:0] o_out_file_bytes;
    logic [63:0] o_out_mem_bytes;
    logic [31:0] o_out_perm_bits;
    logic [63:0] o_plan_start;
    logic [63:0] o_plan_end;
    logic        o_last_result;

    placement_scoreboard sb;
    int n_sent     = 0;
    int n_plans    = 0;
    int n_settings = 0;
    bit calm       = 1'b0;

    elf64_segment_page_placer u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .start            (start),
        .busy             (busy),
        .i_virt_addr      (i_virt_addr),
        .i_mem_bytes      (i_mem_bytes),
        .i_file_pos       (i_file_pos),
        .i_file_bytes     (i_file_bytes),
        .i_perm_bits      (i_perm_bits),
        .i_last_segment   (i_last_segment),
        .o_valid          (o_valid),
        .o_status         (o_status),
        .o_virt_page      (o_virt_page),
        .o_phys_frame     (o_phys_frame),
        .o_phys_addr      (o_phys_addr),
        .o_pages          (o_pages),
        .o_out_file_pos   (o_out_file_pos),
        .o_out_file_bytes (o_out_file_bytes),
        .o_out_mem_bytes  (o_out_mem_bytes),
        .o_out_perm_bits  (o_out_perm_bits),
        .o_plan_start     (o_plan_start),
        .o_plan_end       (o_plan_end),
        .o_last_result    (o_last_result)
    );

    always #5 i_clk = ~i_clk;

    // run limit, far past the slowest legal run
    initial begin
        #5_000_000;
        $display("Timeout with %0d results outstanding", sb.pending());
        $display("Simulation FAILED");
        $finish;
    end

    // result monitor: sample at the edge that ends the strobe cycle
    always @(posedge i_clk) begin : result_monitor
        t_placement got;
        if (i_rst_n === 1'b1 && o_valid === 1'b1) begin
            got.status     = t_status'(o_status);
            got.virt_page  = o_virt_page;
            got.phys_frame = o_phys_frame;
            got.phys_addr  = o_phys_addr;
            got.pages      = o_pages;
            got.file_pos   = o_out_file_pos;
            got.file_bytes = o_out_file_bytes;
            got.mem_bytes  = o_out_mem_bytes;
            got.perm_bits  = o_out_perm_bits;
            got.plan_start = o_plan_start;
            got.plan_end   = o_plan_end;
            got.last       = o_last_result;
            sb.check_result(got);
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic t_segment make_segment(logic [63:0] va, logic [63:0] mem,
                                              bit last, int fill);
        t_segment s;
        s.virt_addr = va;
        s.mem_bytes = mem;
        s.last      = last;
        case (fill)
            FILL_ZERO: begin
                s.file_pos   = '0;
                s.file_bytes = '0;
                s.perm_bits  = '0;
            end
            FILL_ONES: begin
                s.file_pos   = '1;
                s.file_bytes = '1;
                s.perm_bits  = '1;
            end
            default: begin
                s.file_pos   = rand64();
                s.file_bytes = rand64();
                s.perm_bits  = $urandom;
            end
        endcase
        return s;
    endfunction

    // hold off until every predicted result has come and the block is idle
    task automatic drain_results();
        start <= 1'b0;
        @(negedge i_clk);
        while (sb.pending() != 0 || busy !== 1'b0) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    // write both region registers, only while idle
    task automatic write_region(input logic [63:0] base, input logic [63:0] limit);
        drain_results();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_REGION_BASE;
        i_cfg_data <= base;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_REGION_LIMIT;
        i_cfg_data <= limit;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        sb.set_region(base, limit);
        n_settings++;
    endtask

    // offer one segment; start stays high until busy is low at an edge
    task automatic send_segment(input t_segment s);
        calm = (n_sent >= 300 && n_sent < 450);
        if (!calm && $urandom_range(0, 99) < 25) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 30)) @(posedge i_clk);
        end
        start          <= 1'b1;
        i_virt_addr    <= s.virt_addr;
        i_mem_bytes    <= s.mem_bytes;
        i_file_pos     <= s.file_pos;
        i_file_bytes   <= s.file_bytes;
        i_perm_bits    <= s.perm_bits;
        i_last_segment <= s.last;
        do @(posedge i_clk); while (busy !== 1'b0);
        sb.note_item(s);
        n_sent++;
    endtask

    task automatic pick_region(output logic [63:0] base, output logic [63:0] limit);
        case ($urandom_range(0, 11))
            0: begin
                base  = '0;
                limit = '1;
            end
            1: begin
                base  = '1;
                limit = '1;
            end
            2: begin
                base  = rand64();
                limit = '0;
            end
            3: begin
                // cursor near the top: physical end can carry out
                base  = ADDR_MAX - 64'($urandom_range(0, 'h40000));
                limit = '1;
            end
            4: begin
                base  = rand64();
                limit = rand64();
            end
            5, 6: begin
                // page-exact limit so the last page fits or just misses
                base  = (rand64() >> 4) & ~PAGE_MASK;
                limit = base + (64'($urandom_range(1, 40)) << PAGE_BITS);
            end
            default: begin
                base  = rand64() >> 4;
                limit = base + 64'($urandom_range('h8000, 'h100000));
            end
        endcase
    endtask

    // one plan: mostly disjoint segments, some noise and broken ones
    task automatic run_plan();
        int          n_segs;
        int          roll;
        bit          long_plan;
        t_seg_kind   kind;
        logic [63:0] next_va, prev_va, va, mem;
        long_plan = ($urandom_range(0, 4) == 0);
        n_segs    = long_plan ? $urandom_range(14, 18) : $urandom_range(1, 8);
        next_va   = (rand64() >> 1) & ~PAGE_MASK;
        prev_va   = next_va;
        for (int i = 0; i < n_segs; i++) begin
            roll = $urandom_range(0, long_plan ? 39 : 19);
            case (roll)
                0:       kind = SEG_NOISE;
                1:       kind = SEG_OVERLAP;
                2:       kind = SEG_EMPTY;
                3:       kind = SEG_HUGE;
                default: kind = SEG_NORMAL;
            endcase
            case (kind)
                SEG_NOISE: begin
                    va  = rand64();
                    mem = rand64();
                end
                SEG_OVERLAP: begin
                    va  = prev_va + 64'($urandom_range(0, 'hFFF));
                    mem = 64'($urandom_range(1, 'h3000));
                end
                SEG_EMPTY: begin
                    va  = next_va;
                    mem = '0;
                end
                SEG_HUGE: begin
                    va  = next_va + 64'($urandom_range(0, 'hFFF));
                    mem = rand64() >> $urandom_range(0, 24);
                end
                default: begin
                    va      = next_va + 64'($urandom_range(0, 'hFFF));
                    mem     = 64'($urandom_range(0, 'h6000));
                    prev_va = va;
                    next_va = ((va + mem + PAGE_MASK) & ~PAGE_MASK)
                              + (64'($urandom_range(0, 3)) << PAGE_BITS);
                end
            endcase
            // now and then let every result come home first
            if ($urandom_range(0, 99) < 2) drain_results();
            send_segment(make_segment(va, mem, i == n_segs - 1, FILL_RANDOM));
        end
        n_plans++;
    endtask

    initial begin
        logic [63:0] base, limit;
        sb = new();
        i_rst_n        <= 1'b0;
        i_cfg_we       <= 1'b0;
        i_cfg_idx      <= CFG_REGION_BASE;
        i_cfg_data     <= '0;
        start          <= 1'b0;
        i_virt_addr    <= '0;
        i_mem_bytes    <= '0;
        i_file_pos     <= '0;
        i_file_bytes   <= '0;
        i_perm_bits    <= '0;
        i_last_segment <= 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty region: plan opens out of memory
        write_region(64'h0, 64'h0);
        send_segment(make_segment(64'h0, 64'h1000, 1'b1, FILL_ZERO));
        // base rounding overflows
        write_region('1, '1);
        send_segment(make_segment(64'h3000, 64'h10, 1'b1, FILL_ONES));

        write_region(64'h10_0800, 64'h100_0000);
        // virtual end carries out of 64 bits
        send_segment(make_segment('1, 64'h1, 1'b1, FILL_RANDOM));
        // in-page offset plus size carries out
        send_segment(make_segment(64'h0FFF, '1, 1'b1, FILL_ONES));
        // page round-up of the span overflows
        send_segment(make_segment(64'h5000, ADDR_MAX - 64'hFFE, 1'b1, FILL_ZERO));
        // zero size at an aligned address
        send_segment(make_segment(64'h7000, 64'h0, 1'b1, FILL_RANDOM));
        // overlap, then the error stays in force to the end of the plan
        send_segment(make_segment(64'h4_0000, 64'h2000, 1'b0, FILL_RANDOM));
        send_segment(make_segment(64'h4_1800, 64'h10, 1'b0, FILL_RANDOM));
        send_segment(make_segment(64'h9_0000, 64'h1000, 1'b1, FILL_RANDOM));
        // fill every slot, then one more; first one is zero size off-page
        for (int i = 0; i < PLACE_SLOTS + 1; i++)
            send_segment(make_segment(i == 0 ? 64'h20_0123 : 64'h20_0000 + 64'(i) * 64'h1_0000,
                                      i == 0 ? 64'h0 : 64'h800, i == PLACE_SLOTS,
                                      FILL_RANDOM));

        // random plans under changing regions
        while (n_sent < N_ITEMS) begin
            pick_region(base, limit);
            write_region(base, limit);
            repeat ($urandom_range(2, 5)) run_plan();
        end

        drain_results();
        repeat (40) @(posedge i_clk);

        $display("Ran %0d segments in %0d random plans under %0d region settings",
                 n_sent, n_plans, n_settings);
        $display("Outcomes: %0d placed, %0d out of memory, %0d overlap, %0d slots full",
                 sb.status_seen[ST_OK], sb.status_seen[ST_OOM],
                 sb.status_seen[ST_OVERLAP], sb.status_seen[ST_TOOMANY]);
        if (sb.n_mismatch == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("%0d mismatches", sb.n_mismatch);
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

### files.f
src/esp_pkg.sv
src/esp_ram.sv
src/esp_scan.sv
src/elf64_segment_page_placer.sv
bench/elf64_segment_page_placer_tb.sv
